// ----- sv/rebq_pkg.sv -----
// Shared types and constants for the rotary encoder / push switch qualifier.
// Used by rebq_cfg_regs and rotary_encoder_button_qualifier_unit; no dependencies.
package rebq_pkg;

    localparam int TURN_DB_W   = 20;
    localparam int SWITCH_DB_W = 20;
    localparam int LONG_HOLD_W = 26;
    localparam int QUIET_W     = 24;
    localparam int CFG_DATA_W  = 26;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TURN_DB   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_DB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET     = 2'd3;

    localparam logic [TURN_DB_W-1:0]   TURN_DB_RST   = 20'd8000;
    localparam logic [SWITCH_DB_W-1:0] SWITCH_DB_RST = 20'd20000;
    localparam logic [LONG_HOLD_W-1:0] LONG_HOLD_RST = 26'd1000000;
    localparam logic [QUIET_W-1:0]     QUIET_RST     = 24'd500000;

    localparam logic CMD_TURN   = 1'b0;
    localparam logic CMD_SWITCH = 1'b1;

    localparam logic [1:0] EV_RIGHT = 2'd0;
    localparam logic [1:0] EV_LEFT  = 2'd1;
    localparam logic [1:0] EV_PRESS = 2'd2;
    localparam logic [1:0] EV_LONG  = 2'd3;

    typedef struct packed {
        logic [TURN_DB_W-1:0]   turn_db;
        logic [SWITCH_DB_W-1:0] switch_db;
        logic [LONG_HOLD_W-1:0] long_hold;
        logic [QUIET_W-1:0]     quiet;
    } t_cfg;

endpackage

// ----- sv/rotary_encoder_button_qualifier_unit.sv -----
// Rotary encoder and push switch event qualifier, top level.
// Depends on rebq_pkg and rebq_cfg_regs.
//
// Input channel: one pin event per transfer (i_cmd, i_line_b_level,
// i_switch_level, i_stamp_us), accepted when i_in_valid is high and
// o_in_stall is low. Output channel: one event code per transfer on
// o_event_code, taken when o_out_valid is high and i_out_stall is low.
// Events that are debounced away, switch events that fall in the startup
// window, and events that only record a press produce no output transfer.
//
// Timing: an event is held in the input register, where the compares
// against the stored times are made; its result then moves into the
// output register, which drives o_out_valid and o_event_code.
// One event is taken every cycle while the input side does not stall.
// When the receiver stalls, the output register holds its code; events
// that produce no result still retire, and the input side stalls only
// when an event with a result is waiting on a full output register.
// Reset (synchronous, active low) empties both registers, clears the
// stored times and the held flag, and loads the default register values.
// Configuration writes take effect on the next edge.
module rotary_encoder_button_qualifier_unit
    import rebq_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic                  i_line_b_level,
    input  logic                  i_switch_level,
    input  logic [TIME_BITS-1:0]  i_stamp_us,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_event_code
);

    t_cfg w_cfg;

    rebq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // input register
    logic                 r_in_valid;
    logic                 r_cmd;
    logic                 r_b_level;
    logic                 r_sw_level;
    logic [TIME_BITS-1:0] r_stamp;

    // qualifier state
    logic [TIME_BITS-1:0] r_last_turn;
    logic [TIME_BITS-1:0] r_last_switch;
    logic [TIME_BITS-1:0] r_press_start;
    logic                 r_held;

    // output register
    logic       r_out_valid;
    logic [1:0] r_event_code;

    logic [TIME_BITS:0]   w_turn_diff;
    logic [TIME_BITS:0]   w_switch_diff;
    logic [TIME_BITS:0]   w_hold_diff;
    logic [TIME_BITS-1:0] w_turn_gap;
    logic [TIME_BITS-1:0] w_switch_gap;
    logic [TIME_BITS-1:0] w_hold_gap;
    logic [TIME_BITS-1:0] w_quiet;
    logic                 w_turn_ok;
    logic                 w_switch_ok;
    logic                 w_long;
    logic                 w_has_result;
    logic [1:0]           w_code;
    logic                 w_out_free;
    logic                 w_fire;
    logic                 w_in_take;

    assign w_turn_gap   = {{(TIME_BITS-TURN_DB_W){1'b0}}, w_cfg.turn_db};
    assign w_switch_gap = {{(TIME_BITS-SWITCH_DB_W){1'b0}}, w_cfg.switch_db};
    assign w_hold_gap   = {{(TIME_BITS-LONG_HOLD_W){1'b0}}, w_cfg.long_hold};
    assign w_quiet      = {{(TIME_BITS-QUIET_W){1'b0}}, w_cfg.quiet};

    // top bit of each difference is the borrow: time went backwards
    assign w_turn_diff   = {1'b0, r_stamp} - {1'b0, r_last_turn};
    assign w_switch_diff = {1'b0, r_stamp} - {1'b0, r_last_switch};
    assign w_hold_diff   = {1'b0, r_stamp} - {1'b0, r_press_start};

    assign w_turn_ok = !w_turn_diff[TIME_BITS]
                     && (w_turn_diff[TIME_BITS-1:0] >= w_turn_gap);
    assign w_switch_ok = (r_stamp >= w_quiet) && !w_switch_diff[TIME_BITS]
                       && (w_switch_diff[TIME_BITS-1:0] >= w_switch_gap);
    assign w_long = !w_hold_diff[TIME_BITS]
                  && (w_hold_diff[TIME_BITS-1:0] >= w_hold_gap);

    always_comb begin
        if (r_cmd == CMD_TURN) begin
            w_has_result = w_turn_ok;
            w_code       = r_b_level ? EV_LEFT : EV_RIGHT;
        end else begin
            w_has_result = w_switch_ok && r_sw_level && r_held;
            w_code       = w_long ? EV_LONG : EV_PRESS;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && (!w_has_result || w_out_free);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cmd      <= i_cmd;
            r_b_level  <= i_line_b_level;
            r_sw_level <= i_switch_level;
            r_stamp    <= i_stamp_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_turn   <= '0;
            r_last_switch <= '0;
            r_press_start <= '0;
            r_held        <= 1'b0;
        end else if (w_fire) begin
            if (r_cmd == CMD_TURN) begin
                if (w_turn_ok) begin
                    r_last_turn <= r_stamp;
                end
            end else if (w_switch_ok) begin
                r_last_switch <= r_stamp;
                if (!r_sw_level) begin
                    r_press_start <= r_stamp;
                    r_held        <= 1'b1;
                end else begin
                    r_held <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_has_result) begin
            r_event_code <= w_code;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_event_code;

    // a press result needs a press recorded before it
    a_press_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_has_result && r_cmd == CMD_SWITCH) |-> r_held)
        else $error("press reported without a recorded press");

    // an accepted press sets the held flag and records its time
    a_press_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_cmd == CMD_SWITCH && w_switch_ok && !r_sw_level)
        |=> (r_held && r_press_start == $past(r_stamp)))
        else $error("accepted press not recorded");

    // an accepted turn moves the last turn time to its stamp
    a_turn_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_cmd == CMD_TURN && w_turn_ok) |=> (r_last_turn == $past(r_stamp)))
        else $error("accepted turn did not update its time");

    // a pending result is never overwritten while the receiver stalls
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(w_fire && w_has_result))
        else $error("result register overwritten under stall");

    // the input side stalls only with an event waiting
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && w_has_result && r_out_valid))
        else $error("input stalled without a blocked event");

endmodule

// ----- sv/rebq_cfg_regs.sv -----
// Configuration register file: debounce, long-hold and startup-quiet times.
// Depends on rebq_pkg.
module rebq_cfg_regs
    import rebq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turn_db   <= TURN_DB_RST;
            r_cfg.switch_db <= SWITCH_DB_RST;
            r_cfg.long_hold <= LONG_HOLD_RST;
            r_cfg.quiet     <= QUIET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TURN_DB:   r_cfg.turn_db   <= i_cfg_data[TURN_DB_W-1:0];
                REG_SWITCH_DB: r_cfg.switch_db <= i_cfg_data[SWITCH_DB_W-1:0];
                REG_LONG_HOLD: r_cfg.long_hold <= i_cfg_data[LONG_HOLD_W-1:0];
                REG_QUIET:     r_cfg.quiet     <= i_cfg_data[QUIET_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
